[design/sirt_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared widths, register indexes, character codes and the sequencer program
// of the signed integer to radix text block.
// ----------------------------------------------------------------------------
package sirt_pkg;

  // fixed field widths
  localparam int VALUE_W     = 32;
  localparam int CHAR_W      = 8;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int SLOTS       = 16;

  // parameter defaults
  localparam int DEF_MAX_SYMBOLS = 16;
  localparam int DEF_VALUE_BITS  = 32;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_LOW  = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA_HIGH = 8'd1;

  // characters that may not be digit symbols
  localparam logic [CHAR_W-1:0] PLUS_CHAR  = 8'h2B;
  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'h2D;

  // sequencer program counter
  localparam int PC_W = 4;
  typedef logic [PC_W-1:0] pc_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_EMIT_SIGN,
    OP_DIV_START,
    OP_DIV_BIT,
    OP_PUSH,
    OP_EMIT_DIGIT,
    OP_EMIT_ZERO
  } op_t;

  // jump conditions
  typedef enum logic [3:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_BAD,
    COND_ZERO,
    COND_POS,
    COND_OUT_BUSY,
    COND_BIT_MORE,
    COND_QUO_NZ,
    COND_STACK_MORE
  } cond_t;

  // one control word: operation, jump condition, jump target
  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctl_t;

  // step addresses
  localparam pc_t ST_IDLE      = 4'd0;
  localparam pc_t ST_SETTLE    = 4'd1;
  localparam pc_t ST_CHK_BAD   = 4'd2;
  localparam pc_t ST_CHK_ZERO  = 4'd3;
  localparam pc_t ST_CHK_SIGN  = 4'd4;
  localparam pc_t ST_SIGN_WAIT = 4'd5;
  localparam pc_t ST_SIGN      = 4'd6;
  localparam pc_t ST_DIV_INIT  = 4'd7;
  localparam pc_t ST_DIV_BIT   = 4'd8;
  localparam pc_t ST_PUSH      = 4'd9;
  localparam pc_t ST_DIG_WAIT  = 4'd10;
  localparam pc_t ST_DIG       = 4'd11;
  localparam pc_t ST_DONE      = 4'd12;
  localparam pc_t ST_ZERO_WAIT = 4'd13;
  localparam pc_t ST_ZERO      = 4'd14;

  // program rom: a taken jump goes to target, otherwise to the next step
  function automatic ctl_t sirt_rom(input pc_t pc);
    ctl_t w;
    unique case (pc)
      ST_IDLE:      w = '{OP_TAKE,       COND_NO_INPUT,   ST_IDLE};
      ST_SETTLE:    w = '{OP_NONE,       COND_NEVER,      ST_IDLE};
      ST_CHK_BAD:   w = '{OP_NONE,       COND_BAD,        ST_IDLE};
      ST_CHK_ZERO:  w = '{OP_NONE,       COND_ZERO,       ST_ZERO_WAIT};
      ST_CHK_SIGN:  w = '{OP_NONE,       COND_POS,        ST_DIV_INIT};
      ST_SIGN_WAIT: w = '{OP_NONE,       COND_OUT_BUSY,   ST_SIGN_WAIT};
      ST_SIGN:      w = '{OP_EMIT_SIGN,  COND_NEVER,      ST_IDLE};
      ST_DIV_INIT:  w = '{OP_DIV_START,  COND_NEVER,      ST_IDLE};
      ST_DIV_BIT:   w = '{OP_DIV_BIT,    COND_BIT_MORE,   ST_DIV_BIT};
      ST_PUSH:      w = '{OP_PUSH,       COND_QUO_NZ,     ST_DIV_INIT};
      ST_DIG_WAIT:  w = '{OP_NONE,       COND_OUT_BUSY,   ST_DIG_WAIT};
      ST_DIG:       w = '{OP_EMIT_DIGIT, COND_STACK_MORE, ST_DIG_WAIT};
      ST_DONE:      w = '{OP_NONE,       COND_ALWAYS,     ST_IDLE};
      ST_ZERO_WAIT: w = '{OP_NONE,       COND_OUT_BUSY,   ST_ZERO_WAIT};
      ST_ZERO:      w = '{OP_EMIT_ZERO,  COND_ALWAYS,     ST_IDLE};
      default:      w = '{OP_NONE,       COND_ALWAYS,     ST_IDLE};
    endcase
    return w;
  endfunction

endpackage
`default_nettype wire

[design/sirt_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sirt_if
// Valid/ready channels of the block: the number channel and the character
// channel.
// ----------------------------------------------------------------------------
interface sirt_in_if;
  import sirt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface sirt_out_if;
  import sirt_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_out;
  logic              last_char;

  modport source (output valid, output char_out, output last_char, input ready);
  modport sink   (input valid, input char_out, input last_char, output ready);
endinterface
`default_nettype wire

[design/signed_integer_to_radix_text.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text
// Renders a signed number as text in the radix given by a digit alphabet.
// ----------------------------------------------------------------------------
// One number is taken at a time; its characters leave on out_ch, sign first,
// most significant digit next, last_char set on the final one. The alphabet
// (cfg registers 0 and 1, one byte per symbol, ended by the first zero byte)
// is checked every cycle into a register; an invalid alphabet makes a number
// produce no characters. Each digit is one pass of the one-bit-per-cycle
// restoring divider (a start step, then one step per value bit) plus a
// push, a wait step and a pop of the digit stack; a negative number adds a
// wait step and the sign step. A stalled output holds the sequencer in its
// wait step.
// ----------------------------------------------------------------------------
module signed_integer_to_radix_text #(
  parameter int MAX_SYMBOLS = sirt_pkg::DEF_MAX_SYMBOLS,
  parameter int VALUE_BITS  = sirt_pkg::DEF_VALUE_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  sirt_in_if.sink                               in_ch,
  sirt_out_if.source                            out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [sirt_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sirt_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import sirt_pkg::*;

  localparam int SYM_W   = $clog2(MAX_SYMBOLS);
  localparam int NSYM    = 2 ** SYM_W;
  localparam int RADIX_W = $clog2(MAX_SYMBOLS + 1);
  localparam int DIV_W   = SYM_W + 1;
  localparam int CNT_W   = $clog2(VALUE_BITS);
  localparam int IDX_W   = $clog2(VALUE_BITS);
  localparam int SP_W    = $clog2(VALUE_BITS + 1);

  // configuration registers
  logic [CFG_DATA_W-1:0] alpha_low_r;
  logic [CFG_DATA_W-1:0] alpha_high_r;
  logic                  alpha_ok_r;
  logic [RADIX_W-1:0]    radix_r;

  // sequencer
  pc_t  pc_r;
  pc_t  pc_nxt;
  ctl_t ctl;
  logic cond_hit;

  // datapath
  logic [VALUE_BITS-1:0] mag_r;
  logic                  neg_r;
  logic [VALUE_BITS-1:0] q_r;
  logic [SYM_W-1:0]      rem_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [SP_W-1:0]       sp_r;
  logic [SYM_W-1:0]      stack_r [VALUE_BITS];
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     char_r;
  logic                  last_r;

  logic [2*CFG_DATA_W-1:0] alpha_all;
  logic [CHAR_W-1:0]       sym_a [NSYM];
  logic [RADIX_W-1:0]      n_sym;
  logic                    alpha_ok;
  logic                    in_xfer;
  logic                    out_free;
  logic                    emit;
  logic [VALUE_BITS-1:0]   in_low;
  logic [VALUE_BITS-1:0]   in_mag;
  logic [DIV_W-1:0]        shifted;
  logic [DIV_W-1:0]        radix_ext;
  logic [DIV_W-1:0]        diff;
  logic                    ge;
  logic [SP_W-1:0]         sp_m1;

  // symbol slots
  assign alpha_all = {alpha_high_r, alpha_low_r};
  always_comb begin
    for (int k = 0; k < NSYM; k++) begin
      sym_a[k] = alpha_all[k*CHAR_W +: CHAR_W];
    end
  end

  // alphabet length and validity
  always_comb begin
    n_sym = RADIX_W'(MAX_SYMBOLS);
    for (int k = MAX_SYMBOLS - 1; k >= 0; k--) begin
      if (sym_a[k] == '0) begin
        n_sym = RADIX_W'(k);
      end
    end
    alpha_ok = (n_sym >= RADIX_W'(2));
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      if (RADIX_W'(i) < n_sym &&
          (sym_a[i] == PLUS_CHAR || sym_a[i] == MINUS_CHAR)) begin
        alpha_ok = 1'b0;
      end
      for (int j = i + 1; j < MAX_SYMBOLS; j++) begin
        if (RADIX_W'(j) < n_sym && sym_a[i] == sym_a[j]) begin
          alpha_ok = 1'b0;
        end
      end
    end
  end

  // configuration writes and registered alphabet check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_low_r  <= '0;
      alpha_high_r <= '0;
      alpha_ok_r   <= 1'b0;
      radix_r      <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_ALPHA_LOW) begin
        alpha_low_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_ALPHA_HIGH) begin
        alpha_high_r <= cfg_wdata;
      end
      alpha_ok_r <= alpha_ok;
      radix_r    <= n_sym;
    end
  end

  // control word and handshakes
  assign ctl          = sirt_rom(pc_r);
  assign in_ch.ready  = rst_n && (ctl.op == OP_TAKE);
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_free     = !out_valid_r || out_ch.ready;
  assign emit         = (ctl.op == OP_EMIT_SIGN) || (ctl.op == OP_EMIT_DIGIT) ||
                        (ctl.op == OP_EMIT_ZERO);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.char_out  = char_r;
  assign out_ch.last_char = last_r;

  // jump condition
  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:      cond_hit = 1'b0;
      COND_ALWAYS:     cond_hit = 1'b1;
      COND_NO_INPUT:   cond_hit = !in_ch.valid;
      COND_BAD:        cond_hit = !alpha_ok_r;
      COND_ZERO:       cond_hit = (mag_r == '0);
      COND_POS:        cond_hit = !neg_r;
      COND_OUT_BUSY:   cond_hit = !out_free;
      COND_BIT_MORE:   cond_hit = (cnt_r != '0);
      COND_QUO_NZ:     cond_hit = (q_r != '0);
      COND_STACK_MORE: cond_hit = (sp_r > SP_W'(1));
      default:         cond_hit = 1'b1;
    endcase
    pc_nxt = cond_hit ? ctl.target : pc_t'(pc_r + pc_t'(1));
  end

  // magnitude of the incoming value
  assign in_low = in_ch.value[VALUE_BITS-1:0];
  assign in_mag = in_low[VALUE_BITS-1] ? (~in_low + VALUE_BITS'(1)) : in_low;

  // restoring divider step
  assign shifted   = {rem_r, q_r[VALUE_BITS-1]};
  assign radix_ext = DIV_W'(radix_r);
  assign diff      = shifted - radix_ext;
  assign ge        = (shifted >= radix_ext);

  // digit stack top address
  assign sp_m1     = sp_r - SP_W'(1);

  // sequencer state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= ST_IDLE;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r <= pc_nxt;
      // load on emit, clear once the pending transfer is taken
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctl.op)
        OP_TAKE: begin
          if (in_xfer) begin
            sp_r <= '0;
          end
        end
        OP_PUSH: begin
          sp_r <= SP_W'(sp_r + SP_W'(1));
        end
        OP_EMIT_DIGIT: begin
          sp_r <= sp_m1;
        end
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_TAKE: begin
        if (in_xfer) begin
          mag_r <= in_mag;
          neg_r <= in_low[VALUE_BITS-1];
        end
      end
      OP_EMIT_SIGN: begin
        char_r <= MINUS_CHAR;
        last_r <= 1'b0;
      end
      OP_DIV_START: begin
        q_r   <= mag_r;
        rem_r <= '0;
        cnt_r <= CNT_W'(VALUE_BITS - 1);
      end
      OP_DIV_BIT: begin
        q_r   <= {q_r[VALUE_BITS-2:0], ge};
        rem_r <= ge ? diff[SYM_W-1:0] : shifted[SYM_W-1:0];
        cnt_r <= cnt_r - CNT_W'(1);
      end
      OP_PUSH: begin
        stack_r[sp_r[IDX_W-1:0]] <= rem_r;
        mag_r                    <= q_r;
      end
      OP_EMIT_DIGIT: begin
        char_r <= sym_a[stack_r[sp_m1[IDX_W-1:0]]];
        last_r <= (sp_r == SP_W'(1));
      end
      OP_EMIT_ZERO: begin
        char_r <= sym_a[0];
        last_r <= 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  // a character is only loaded when the output register is free
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("character loaded over a pending transfer");

  // digits are only popped from a non-empty stack
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_EMIT_DIGIT) |-> (sp_r != '0))
    else $error("digit stack underflow");

  // the stack never holds more digits than the value has bits
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_PUSH) |-> (sp_r < SP_W'(VALUE_BITS)))
    else $error("digit stack overflow");

  // a pushed remainder is a valid digit of the radix
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == OP_PUSH) |-> (DIV_W'(rem_r) < radix_ext))
    else $error("remainder not below radix");
`endif

endmodule
`default_nettype wire

[dv/signed_integer_to_radix_text_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_to_radix_text_tb
// Feeds signed numbers under a range of digit alphabets and checks every
// character transfer against a predicted text stream, with random idling on
// both channels, a long output hold-off and a full drain in mid-phase.
// ----------------------------------------------------------------------------
import sirt_pkg::*;

// one predicted character of a number's text
typedef struct packed {
  logic [CHAR_W-1:0] ch;
  logic              is_last;
} text_char_t;

// ways of spoiling an otherwise good alphabet
typedef enum int unsigned {
  FAULT_PLUS,
  FAULT_MINUS,
  FAULT_REPEAT,
  FAULT_SHORT
} alpha_fault_t;

// predicts the text of each accepted number and checks the character stream
class text_scoreboard;
  logic [CFG_DATA_W-1:0] alpha_low;
  logic [CFG_DATA_W-1:0] alpha_high;
  text_char_t            pending_chars[$];
  int unsigned           errors;
  int unsigned           numbers_noted;
  int unsigned           chars_checked;

  function new();
    alpha_low     = '0;
    alpha_high    = '0;
    errors        = 0;
    numbers_noted = 0;
    chars_checked = 0;
  endfunction

  // mirror of the register file; unknown indexes change nothing
  function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    if (index == CFG_ALPHA_LOW) begin
      alpha_low = data;
    end else if (index == CFG_ALPHA_HIGH) begin
      alpha_high = data;
    end
  endfunction

  function logic [CHAR_W-1:0] symbol(int unsigned k);
    logic [CFG_DATA_W-1:0] word;
    word = (k < 8) ? alpha_low : alpha_high;
    return word[(k % 8) * CHAR_W +: CHAR_W];
  endfunction

  // number of symbols, or 0 when the alphabet cannot be used
  function int unsigned radix();
    int unsigned n;
    n = 0;
    while (n < DEF_MAX_SYMBOLS && n < SLOTS && symbol(n) != '0) n++;
    if (n < 2) return 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (symbol(i) == PLUS_CHAR || symbol(i) == MINUS_CHAR) return 0;
      for (int unsigned j = i + 1; j < n; j++) begin
        if (symbol(j) == symbol(i)) return 0;
      end
    end
    return n;
  endfunction

  function int unsigned pending();
    return pending_chars.size();
  endfunction

  // accepted number: queue its text, sign first, most significant digit next
  function void note_number(logic signed [VALUE_W-1:0] value);
    logic [VALUE_W-1:0] mag;
    logic [CHAR_W-1:0]  digits[$];
    logic [CHAR_W-1:0]  d;
    int unsigned        r;
    numbers_noted++;
    r = radix();
    if (r == 0) return;
    if (value == 0) begin
      pending_chars.push_back('{ch: symbol(0), is_last: 1'b1});
      return;
    end
    if (value[VALUE_W-1]) begin
      // two's complement wrap keeps the most negative value exact
      mag = ~value + 1'b1;
      pending_chars.push_back('{ch: MINUS_CHAR, is_last: 1'b0});
    end else begin
      mag = value;
    end
    while (mag != 0) begin
      digits.push_front(symbol(mag % r));
      mag = mag / r;
    end
    while (digits.size() > 0) begin
      d = digits.pop_front();
      pending_chars.push_back('{ch: d, is_last: (digits.size() == 0)});
    end
  endfunction

  // character transfer: compare with the oldest prediction
  function void check_char(logic [CHAR_W-1:0] ch, logic is_last);
    text_char_t want;
    chars_checked++;
    if (pending_chars.size() == 0) begin
      $error("unexpected character: char_out %02h last_char %0b", ch, is_last);
      errors++;
      return;
    end
    want = pending_chars.pop_front();
    if (ch !== want.ch) begin
      $error("char_out mismatch: expected %02h, actual %02h", want.ch, ch);
      errors++;
    end
    if (is_last !== want.is_last) begin
      $error("last_char mismatch: expected %0b, actual %0b", want.is_last, is_last);
      errors++;
    end
  endfunction
endclass

module signed_integer_to_radix_text_tb;

  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 8'd7;
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 400;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  sirt_in_if  in_ch ();
  sirt_out_if out_ch ();

  text_scoreboard sb;
  bit             steady;
  int unsigned    hold_req;
  int unsigned    settings_count;
  int unsigned    cycle_count;

  signed_integer_to_radix_text u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // transfer monitor on both channels
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) sb.note_number(in_ch.value);
      if (out_ch.valid && out_ch.ready) sb.check_char(out_ch.char_out, out_ch.last_char);
    end
  end

  // character receiver: random idling, steady stretches and one long hold-off
  initial begin
    int unsigned w;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      w = steady ? 0 : $urandom_range(0, 4);
      if (hold_req != 0) begin
        w += hold_req;
        hold_req = 0;
      end
      if (w > 0) begin
        out_ch.ready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid && hold_req == 0);
    end
  end

  // alphabet text packed symbol 0 first
  function automatic logic [127:0] pack_text(string s);
    logic [127:0] a;
    a = '0;
    for (int i = 0; i < s.len() && i < SLOTS; i++) a[8*i +: 8] = s[i];
    return a;
  endfunction

  // random alphabet of r distinct symbols, junk after the terminator
  function automatic logic [127:0] random_alphabet(int unsigned r, bit broken);
    logic [CHAR_W-1:0] sym [SLOTS];
    logic [127:0]      a;
    logic [CHAR_W-1:0] c;
    bit                fresh;
    int unsigned       pos;
    alpha_fault_t      fault;
    for (int unsigned k = 0; k < r; k++) begin
      do begin
        c = CHAR_W'($urandom_range(1, 255));
        fresh = (c != PLUS_CHAR && c != MINUS_CHAR);
        for (int unsigned j = 0; j < k; j++) if (sym[j] == c) fresh = 1'b0;
      end while (!fresh);
      sym[k] = c;
    end
    for (int unsigned k = r; k < SLOTS; k++) begin
      sym[k] = (k == r) ? 8'h00 : CHAR_W'($urandom_range(0, 255));
    end
    if (broken) begin
      pos   = $urandom_range(0, r - 1);
      fault = alpha_fault_t'($urandom_range(0, 3));
      case (fault)
        FAULT_PLUS:   sym[pos] = PLUS_CHAR;
        FAULT_MINUS:  sym[pos] = MINUS_CHAR;
        FAULT_REPEAT: sym[pos] = sym[(pos + 1) % r];
        default:      sym[$urandom_range(0, 1)] = 8'h00;
      endcase
    end
    for (int unsigned k = 0; k < SLOTS; k++) a[8*k +: 8] = sym[k];
    return a;
  endfunction

  // mix of full-range, small, power-of-two and extreme values
  function automatic logic signed [VALUE_W-1:0] random_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1, 2: v = $urandom;
      3: begin
        v = $urandom_range(0, 40);
        if ($urandom_range(0, 1)) v = -v;
      end
      4: begin
        v = 32'sd1 <<< $urandom_range(0, 31);
        if ($urandom_range(0, 1)) v = v - 1;
        if ($urandom_range(0, 1)) v = -v;
      end
      default: v = {($urandom_range(0, 1) == 1), {31{($urandom_range(0, 1) == 1)}}};
    endcase
    return v;
  endfunction

  // one number transfer after a random gap
  task automatic send_number(input logic signed [VALUE_W-1:0] value);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // stop offering, let every predicted character arrive, then settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(index, data);
  endtask

  // new alphabet, written only once the block is idle
  task automatic set_alphabet(input logic [127:0] alpha);
    wait_idle();
    write_reg(CFG_ALPHA_LOW, alpha[63:0]);
    write_reg(CFG_ALPHA_HIGH, alpha[127:64]);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    settings_count++;
  endtask

  // main sequence
  initial begin
    bit          broken;
    int unsigned r;
    int unsigned n;
    sb             = new();
    steady         = 1'b0;
    hold_req       = 0;
    settings_count = 0;
    rst_n       <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    cfg_we      <= 1'b0;
    cfg_index   <= '0;
    cfg_wdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty alphabet after reset: numbers give no text
    send_number(5);
    send_number(-7);

    // decimal with zero, unit and extreme values
    set_alphabet(pack_text("0123456789"));
    send_number(0);
    send_number(1);
    send_number(-1);
    send_number(32'sh7FFF_FFFF);
    send_number(32'sh8000_0000);
    send_number(1234567890);

    // write to an unused index leaves the alphabet alone
    wait_idle();
    write_reg(CFG_SPARE, {$urandom, $urandom});
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
    send_number(42);

    // smallest radix: longest texts
    set_alphabet(pack_text("01"));
    send_number(32'sh8000_0000);
    send_number(32'sh7FFF_FFFF);

    // largest radix
    set_alphabet(pack_text("0123456789ABCDEF"));
    send_number(32'shDEAD_BEEF);
    send_number(255);

    // high-bit symbols, zero uses symbol 0
    set_alphabet(128'h01FF);
    send_number(0);
    send_number(6);

    // bad alphabets: single symbol, plus, minus, repeat, empty, repeat in high word
    set_alphabet(pack_text("7"));
    send_number(3);
    set_alphabet(pack_text("0+1"));
    send_number(-3);
    set_alphabet(pack_text("01-"));
    send_number(9);
    set_alphabet(pack_text("0120"));
    send_number(0);
    set_alphabet(128'h3938_3736_3534_3300);
    send_number(-100);
    set_alphabet(pack_text("0123456789ABCDE0"));
    send_number(77);

    // random phases, each under a fresh alphabet
    for (int unsigned phase = 0; phase < 12; phase++) begin
      broken = (phase == 4 || phase == 9);
      r = (phase == 0) ? 2 : (phase == 1) ? 16 : $urandom_range(2, 16);
      set_alphabet(random_alphabet(r, broken));
      steady = (phase == 3 || phase == 6);
      // output held off while the sender keeps offering
      if (phase == 6) hold_req = HOLD_CYCLES;
      n = broken ? 8 : 36;
      for (int unsigned i = 0; i < n; i++) begin
        // sender pause until the block has drained
        if (phase == 7 && i == 18) wait_idle();
        send_number(random_value());
      end
      steady = 1'b0;
    end
    wait_idle();

    $display("tb: rendered %0d numbers into %0d characters under %0d alphabets",
             sb.numbers_noted, sb.chars_checked, settings_count);
    $display("tb: radix 2 to 16, bad alphabets, signs, zero, output hold-off, drains");
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

[filelist.f]
design/sirt_pkg.sv
design/sirt_if.sv
design/signed_integer_to_radix_text.sv
dv/signed_integer_to_radix_text_tb.sv
